// ----- hw/rtl/prf_pkg.sv -----
// Package for the packet ring FIFO: ring geometry, operation codes, controller states,
// beat payload structs and the command/status structs between controller and datapath.
// No dependencies.
package prf_pkg;

  localparam int RING_DEPTH = 512;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int HDR_BYTES  = 4;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [PTR_W:0]   ext_t;

  typedef enum logic [2:0] {
    OP_RX_HDR  = 3'd0,
    OP_RX_BYTE = 3'd1,
    OP_PARSE   = 3'd2,
    OP_READ    = 3'd3,
    OP_PEEK    = 3'd4,
    OP_PURGE   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_HDR_WR,
    ST_PARSE_RD,
    ST_MEM_RD,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         rx_length;
    logic signed [15:0] rx_rssi;
    logic signed [7:0]  rx_snr;
    logic [7:0]         rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         data_out;
    logic               empty_res;
    logic               accepted;
    logic               packet_found;
    logic [7:0]         packet_length;
    logic signed [15:0] packet_rssi;
    logic signed [7:0]  packet_snr;
    logic [8:0]         bytes_left;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic hdr_wr;
    logic parse_rd;
    logic rd_cap;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic hdr_fit;
    logic pkt_avail;
    logic byte_avail;
    logic hdr_last;
    logic parse_last;
  } dp_sts_t;

endpackage

// ----- hw/rtl/prf_dp.sv -----
// Datapath of the packet ring FIFO: byte ring memory, pointers, open-packet
// metadata and the output register. Driven by prf_ctrl; depends on prf_pkg.
module prf_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  prf_pkg::in_item_t   in_data,
  input  prf_pkg::dp_cmd_t    cmd,
  output prf_pkg::dp_sts_t    sts,
  output prf_pkg::out_item_t  out_data
);

  function automatic prf_pkg::ptr_t next_pos(input prf_pkg::ptr_t p);
    return (p == prf_pkg::ptr_t'(prf_pkg::RING_DEPTH - 1)) ? '0 : p + prf_pkg::ptr_t'(1);
  endfunction

  function automatic prf_pkg::ptr_t wrap_add(input prf_pkg::ptr_t p, input logic [7:0] n);
    prf_pkg::ext_t sum;
    sum = prf_pkg::ext_t'(p) + prf_pkg::ext_t'(n);
    if (sum >= prf_pkg::ext_t'(prf_pkg::RING_DEPTH)) begin
      sum = sum - prf_pkg::ext_t'(prf_pkg::RING_DEPTH);
    end
    return sum[prf_pkg::PTR_W-1:0];
  endfunction

  logic [7:0] ring_mem_r [prf_pkg::RING_DEPTH];
  logic [7:0] rdata_r;

  prf_pkg::in_item_t  item_r, item_nxt;
  prf_pkg::ptr_t      commit_r, commit_nxt;
  prf_pkg::ptr_t      staging_r, staging_nxt;
  prf_pkg::ptr_t      pstart_r, pstart_nxt;
  prf_pkg::ptr_t      rptr_r, rptr_nxt;
  prf_pkg::ptr_t      pend_r, pend_nxt;
  prf_pkg::ptr_t      wp_r, wp_nxt;
  logic [7:0]         btw_r, btw_nxt;
  logic               writing_r, writing_nxt;
  logic               popen_r, popen_nxt;
  logic [7:0]         olen_r, olen_nxt;
  logic [15:0]        orssi_r, orssi_nxt;
  logic [7:0]         osnr_r, osnr_nxt;
  logic [2:0]         step_r, step_nxt;
  logic [7:0]         data_r, data_nxt;
  logic               empty_r, empty_nxt;
  logic               acc_r, acc_nxt;
  logic               found_r, found_nxt;
  prf_pkg::out_item_t out_r, out_nxt;

  logic               mem_we, mem_re;
  prf_pkg::ptr_t      mem_wa, mem_ra;
  logic [7:0]         mem_wd;

  prf_pkg::op_t       op;
  prf_pkg::ext_t      free_sp, need_sp, avail;
  prf_pkg::ptr_t      pstart_eff;
  logic [7:0]         hdr_byte;

  assign op = prf_pkg::op_t'(item_r.operation);

  // Free space counts from the start of the packet being read; one entry stays free.
  always_comb begin
    if (commit_r < pstart_r) begin
      free_sp = prf_pkg::ext_t'(pstart_r) - prf_pkg::ext_t'(commit_r) - prf_pkg::ext_t'(1);
    end else begin
      free_sp = prf_pkg::ext_t'(prf_pkg::RING_DEPTH) - prf_pkg::ext_t'(commit_r)
              + prf_pkg::ext_t'(pstart_r) - prf_pkg::ext_t'(1);
    end
    need_sp = prf_pkg::ext_t'(item_r.rx_length) + prf_pkg::ext_t'(prf_pkg::HDR_BYTES);
    if (pend_r >= rptr_r) begin
      avail = prf_pkg::ext_t'(pend_r) - prf_pkg::ext_t'(rptr_r);
    end else begin
      avail = prf_pkg::ext_t'(pend_r) + prf_pkg::ext_t'(prf_pkg::RING_DEPTH)
            - prf_pkg::ext_t'(rptr_r);
    end
  end

  // Parse first steps past an open packet.
  assign pstart_eff = popen_r ? pend_r : pstart_r;

  always_comb begin
    case (step_r[1:0])
      2'd0:    hdr_byte = item_r.rx_length;
      2'd1:    hdr_byte = item_r.rx_rssi[7:0];
      2'd2:    hdr_byte = item_r.rx_rssi[15:8];
      default: hdr_byte = item_r.rx_snr;
    endcase
  end

  always_comb begin
    sts.op         = op;
    sts.hdr_fit    = (free_sp >= need_sp);
    sts.pkt_avail  = (pstart_eff != commit_r);
    sts.byte_avail = (rptr_r != pend_r);
    sts.hdr_last   = (step_r == 3'd3);
    sts.parse_last = (step_r == 3'd4);
  end

  always_comb begin
    item_nxt    = item_r;
    commit_nxt  = commit_r;
    staging_nxt = staging_r;
    pstart_nxt  = pstart_r;
    rptr_nxt    = rptr_r;
    pend_nxt    = pend_r;
    wp_nxt      = wp_r;
    btw_nxt     = btw_r;
    writing_nxt = writing_r;
    popen_nxt   = popen_r;
    olen_nxt    = olen_r;
    orssi_nxt   = orssi_r;
    osnr_nxt    = osnr_r;
    step_nxt    = step_r;
    data_nxt    = data_r;
    empty_nxt   = empty_r;
    acc_nxt     = acc_r;
    found_nxt   = found_r;
    out_nxt     = out_r;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = '0;

    if (cmd.capture) begin
      item_nxt  = in_data;
      data_nxt  = '0;
      empty_nxt = 1'b0;
      acc_nxt   = 1'b0;
      found_nxt = 1'b0;
    end

    if (cmd.exec) begin
      case (op)
        prf_pkg::OP_RX_HDR: begin
          // drop any partial packet and restage from the commit point
          writing_nxt = 1'b0;
          if (sts.hdr_fit) begin
            acc_nxt  = 1'b1;
            wp_nxt   = commit_r;
            btw_nxt  = item_r.rx_length;
            step_nxt = '0;
          end
        end
        prf_pkg::OP_RX_BYTE: begin
          if (writing_r) begin
            mem_we      = 1'b1;
            mem_wa      = staging_r;
            mem_wd      = item_r.rx_byte;
            staging_nxt = next_pos(staging_r);
            btw_nxt     = btw_r - 8'd1;
            if (btw_r == 8'd1) begin
              commit_nxt  = next_pos(staging_r);
              writing_nxt = 1'b0;
            end
          end
        end
        prf_pkg::OP_PARSE: begin
          if (popen_r) begin
            rptr_nxt   = pend_r;
            pstart_nxt = pend_r;
            popen_nxt  = 1'b0;
            olen_nxt   = '0;
            orssi_nxt  = '0;
            osnr_nxt   = '0;
          end
          if (sts.pkt_avail) begin
            wp_nxt   = pstart_eff;
            step_nxt = '0;
          end
        end
        prf_pkg::OP_READ, prf_pkg::OP_PEEK: begin
          if (sts.byte_avail) begin
            mem_re = 1'b1;
            mem_ra = rptr_r;
          end else begin
            empty_nxt = 1'b1;
          end
        end
        prf_pkg::OP_PURGE: begin
          pstart_nxt = commit_r;
          rptr_nxt   = commit_r;
          pend_nxt   = commit_r;
          popen_nxt  = 1'b0;
          olen_nxt   = '0;
          orssi_nxt  = '0;
          osnr_nxt   = '0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.hdr_wr) begin
      mem_we   = 1'b1;
      mem_wa   = wp_r;
      mem_wd   = hdr_byte;
      wp_nxt   = next_pos(wp_r);
      step_nxt = step_r + 3'd1;
      if (sts.hdr_last) begin
        staging_nxt = next_pos(wp_r);
        if (item_r.rx_length == 8'd0) begin
          commit_nxt = next_pos(wp_r);
        end else begin
          writing_nxt = 1'b1;
        end
      end
    end

    // Header reads overlap: issue byte k while capturing byte k-1.
    if (cmd.parse_rd) begin
      step_nxt = step_r + 3'd1;
      if (!sts.parse_last) begin
        mem_re = 1'b1;
        mem_ra = wp_r;
        wp_nxt = next_pos(wp_r);
      end
      case (step_r)
        3'd1:    olen_nxt = rdata_r;
        3'd2:    orssi_nxt[7:0] = rdata_r;
        3'd3:    orssi_nxt[15:8] = rdata_r;
        3'd4:    osnr_nxt = rdata_r;
        default: begin
        end
      endcase
      if (sts.parse_last) begin
        rptr_nxt  = wp_r;
        pend_nxt  = wrap_add(wp_r, olen_r);
        popen_nxt = 1'b1;
        found_nxt = 1'b1;
      end
    end

    if (cmd.rd_cap) begin
      data_nxt = rdata_r;
      if (op == prf_pkg::OP_READ) begin
        rptr_nxt = next_pos(rptr_r);
      end
    end

    if (cmd.load_out) begin
      out_nxt.data_out      = data_r;
      out_nxt.empty_res     = empty_r;
      out_nxt.accepted      = acc_r;
      out_nxt.packet_found  = found_r;
      out_nxt.packet_length = olen_r;
      out_nxt.packet_rssi   = orssi_r;
      out_nxt.packet_snr    = osnr_r;
      out_nxt.bytes_left    = avail[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= ring_mem_r[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      commit_r  <= '0;
      staging_r <= '0;
      pstart_r  <= '0;
      rptr_r    <= '0;
      pend_r    <= '0;
      btw_r     <= '0;
      writing_r <= 1'b0;
      popen_r   <= 1'b0;
      olen_r    <= '0;
      orssi_r   <= '0;
      osnr_r    <= '0;
    end else begin
      commit_r  <= commit_nxt;
      staging_r <= staging_nxt;
      pstart_r  <= pstart_nxt;
      rptr_r    <= rptr_nxt;
      pend_r    <= pend_nxt;
      btw_r     <= btw_nxt;
      writing_r <= writing_nxt;
      popen_r   <= popen_nxt;
      olen_r    <= olen_nxt;
      orssi_r   <= orssi_nxt;
      osnr_r    <= osnr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    wp_r    <= wp_nxt;
    step_r  <= step_nxt;
    data_r  <= data_nxt;
    empty_r <= empty_nxt;
    acc_r   <= acc_nxt;
    found_r <= found_nxt;
    out_r   <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ----- hw/rtl/prf_ctrl.sv -----
// Controller of the packet ring FIFO: sequences capture, execute, header
// writes, header reads, byte reads and the output beat. Depends on prf_pkg.
module prf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  prf_pkg::dp_sts_t  sts,
  output prf_pkg::dp_cmd_t  cmd
);

  prf_pkg::st_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prf_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      prf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = prf_pkg::ST_EXEC;
        end
      end
      prf_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.op)
          prf_pkg::OP_RX_HDR:
            state_nxt = sts.hdr_fit ? prf_pkg::ST_HDR_WR : prf_pkg::ST_DONE;
          prf_pkg::OP_PARSE:
            state_nxt = sts.pkt_avail ? prf_pkg::ST_PARSE_RD : prf_pkg::ST_DONE;
          prf_pkg::OP_READ,
          prf_pkg::OP_PEEK:
            state_nxt = sts.byte_avail ? prf_pkg::ST_MEM_RD : prf_pkg::ST_DONE;
          default:
            state_nxt = prf_pkg::ST_DONE;
        endcase
      end
      prf_pkg::ST_HDR_WR: begin
        cmd.hdr_wr = 1'b1;
        if (sts.hdr_last) begin
          state_nxt = prf_pkg::ST_DONE;
        end
      end
      prf_pkg::ST_PARSE_RD: begin
        cmd.parse_rd = 1'b1;
        if (sts.parse_last) begin
          state_nxt = prf_pkg::ST_DONE;
        end
      end
      prf_pkg::ST_MEM_RD: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = prf_pkg::ST_DONE;
      end
      prf_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = prf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = prf_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/packet_ring_fifo_with_metadata.sv -----
// Packet ring FIFO with per-packet metadata. Each input beat is captured and executed;
// then a stored header passes the header-write state, a parse that opens a packet
// the header-read state, a read or peek that returns a byte the memory-read state,
// and the output register loads once it is free. No new beat is taken until then.
// Synchronous active-low reset clears pointers and metadata; ring contents are
// left undefined and need no clearing pass.
module packet_ring_fifo_with_metadata (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prf_pkg::out_item_t  out_data
);

  prf_pkg::dp_cmd_t cmd;
  prf_pkg::dp_sts_t sts;

  prf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
